// ----- rtl/dmvr_pkg.sv -----
// dmvr_pkg: shared types, constants and helper functions for the dual motor velocity ramp
// no dependencies; imported by every module of the block

package dmvr_pkg;

  localparam int unsigned RAMP_TICKS_DEF = 200;
  localparam int unsigned CNT_W          = 8;
  localparam int unsigned VAL_W          = 16;
  localparam int unsigned DUTY_W         = 15;

  localparam logic signed [VAL_W-1:0] DUTY_MAX = 16'sd32767;
  localparam logic signed [VAL_W-1:0] DUTY_MIN = -16'sd32767;

  typedef enum logic {
    OP_CMD  = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic signed [VAL_W-1:0]  target_left;
    logic signed [VAL_W-1:0]  target_right;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_forward;
    logic [DUTY_W-1:0] left_backward;
    logic [DUTY_W-1:0] right_forward;
    logic [DUTY_W-1:0] right_backward;
    logic              ramping;
  } out_word_t;

  // result handed from the ramp datapath to the output register
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } ramp_res_t;

  typedef struct packed {
    logic [DUTY_W-1:0] fwd;
    logic [DUTY_W-1:0] back;
  } duty_pair_t;

  // only the most negative code falls outside the duty range
  function automatic logic signed [VAL_W-1:0] clip16(input logic signed [VAL_W-1:0] v);
    clip16 = (v == {1'b1, {(VAL_W-1){1'b0}}}) ? DUTY_MIN : v;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat17(input logic signed [VAL_W:0] v);
    if (v > $signed({DUTY_MAX[VAL_W-1], DUTY_MAX})) begin
      sat17 = DUTY_MAX;
    end else if (v < $signed({DUTY_MIN[VAL_W-1], DUTY_MIN})) begin
      sat17 = DUTY_MIN;
    end else begin
      sat17 = v[VAL_W-1:0];
    end
  endfunction

  // value is already within +-32767
  function automatic duty_pair_t split(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] neg;
    neg = -v;
    if (v[VAL_W-1]) begin
      split.fwd  = '0;
      split.back = neg[DUTY_W-1:0];
    end else begin
      split.fwd  = v[DUTY_W-1:0];
      split.back = '0;
    end
  endfunction

endpackage

// ----- rtl/dual_motor_velocity_ramp_core.sv -----
// Dual motor soft-start ramp. Each input word is either a velocity command (opcode 0, signed
// Q1.15 left/right targets) or a timer tick (opcode 1). Commands give no output word; a tick
// gives one word with forward/backward duties for both motors, except the first tick after a
// new nonzero command, which loads the ramp counter with RAMP_TICKS and gives nothing. A word
// is taken into an input register and handled from there by one pass of logic that updates
// the ramp state and fills the output register, so one word is accepted per cycle; a tick
// waits in the input register only while a finished output word is held by out_stall.
// depends on dmvr_pkg, dmvr_ramp, dmvr_step

module dual_motor_velocity_ramp_core import dmvr_pkg::*; #(
  parameter int unsigned RAMP_TICKS = RAMP_TICKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      in_vld_r, in_vld_nxt;
  in_word_t  in_r;
  logic      out_vld_r, out_vld_nxt;
  out_word_t out_r;
  logic      out_free, fire;
  ramp_res_t res;

  // a command never produces a word, so it need not wait for the output
  assign out_free = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && (out_free || in_r.opcode == OP_CMD);
  assign in_stall = in_vld_r && !fire;

  dmvr_ramp #(.RAMP_TICKS(RAMP_TICKS)) u_ramp (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_r),
    .res   (res)
  );

  always_comb begin
    in_vld_nxt = in_stall ? in_vld_r : in_valid;
    if (res.valid) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_r <= in_word;
    end
    if (res.valid) begin
      out_r <= res.word;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !(out_vld_r && out_stall))
    else $error("output word overwritten while held");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with empty input register");

  a_left_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.left_forward == '0 || out_word.left_backward == '0))
    else $error("left motor driven both ways");

  a_right_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.right_forward == '0 || out_word.right_backward == '0))
    else $error("right motor driven both ways");
`endif

endmodule

// ----- rtl/dmvr_step.sv -----
// dmvr_step: per-tick step (goal - current) / RAMP_TICKS, truncated toward zero, saturated
// depends on dmvr_pkg; divide by constant done as a reciprocal multiply

module dmvr_step import dmvr_pkg::*; #(
  parameter int unsigned RAMP_TICKS = RAMP_TICKS_DEF
) (
  input  logic signed [VAL_W-1:0] goal,
  input  logic signed [VAL_W-1:0] cur,
  output logic signed [VAL_W-1:0] step
);

  localparam int unsigned MAG_W   = VAL_W + 1;
  localparam int unsigned SHIFT   = MAG_W + CNT_W;
  localparam int unsigned RECIP_W = SHIFT + 1;
  localparam int unsigned PROD_W  = MAG_W + RECIP_W;
  // ceil(2^SHIFT / N) is exact for every magnitude below 2^MAG_W
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(RAMP_TICKS) - 64'd1) / 64'(RAMP_TICKS));

  logic signed [MAG_W-1:0] diff;
  logic        [MAG_W-1:0] mag;
  logic       [PROD_W-1:0] prod;
  logic        [MAG_W-1:0] quo;
  logic signed [VAL_W-1:0] quo_sat;

  always_comb begin
    diff = {goal[VAL_W-1], goal} - {cur[VAL_W-1], cur};
    mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    prod = PROD_W'(mag) * PROD_W'(RECIP);
    quo  = prod[SHIFT +: MAG_W];
    if (quo > MAG_W'(DUTY_MAX)) begin
      quo_sat = DUTY_MAX;
    end else begin
      quo_sat = quo[VAL_W-1:0];
    end
    step = diff[MAG_W-1] ? -quo_sat : quo_sat;
  end

endmodule

// ----- rtl/dmvr_ramp.sv -----
// dmvr_ramp: ramp state registers and the single-pass command / tick datapath
// depends on dmvr_pkg and dmvr_step

module dmvr_ramp import dmvr_pkg::*; #(
  parameter int unsigned RAMP_TICKS = RAMP_TICKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_word_t  item,
  output ramp_res_t res
);

  logic signed [VAL_W-1:0] last_l_r, last_l_nxt, last_r_r, last_r_nxt;
  logic signed [VAL_W-1:0] goal_l_r, goal_l_nxt, goal_r_r, goal_r_nxt;
  logic signed [VAL_W-1:0] cur_l_r, cur_l_nxt, cur_r_r, cur_r_nxt;
  logic signed [VAL_W-1:0] inc_l_r, inc_l_nxt, inc_r_r, inc_r_nxt;
  logic        [CNT_W-1:0] ticks_r, ticks_nxt;
  logic                    armed_r, armed_nxt;

  logic signed [VAL_W-1:0] tl, tr, step_l, step_r, rep_l, rep_r;
  logic                    rep_ramping;
  duty_pair_t              dl, dr;

  assign tl = clip16(item.target_left);
  assign tr = clip16(item.target_right);

  dmvr_step #(.RAMP_TICKS(RAMP_TICKS)) u_step_l (.goal(tl), .cur(cur_l_r), .step(step_l));
  dmvr_step #(.RAMP_TICKS(RAMP_TICKS)) u_step_r (.goal(tr), .cur(cur_r_r), .step(step_r));

  always_comb begin
    last_l_nxt  = last_l_r;
    last_r_nxt  = last_r_r;
    goal_l_nxt  = goal_l_r;
    goal_r_nxt  = goal_r_r;
    cur_l_nxt   = cur_l_r;
    cur_r_nxt   = cur_r_r;
    inc_l_nxt   = inc_l_r;
    inc_r_nxt   = inc_r_r;
    ticks_nxt   = ticks_r;
    armed_nxt   = armed_r;
    res.valid   = 1'b0;
    rep_l       = goal_l_r;
    rep_r       = goal_r_r;
    rep_ramping = 1'b0;

    if (fire) begin
      if (item.opcode == OP_CMD) begin
        if (!(tl == last_l_r && tr == last_r_r)) begin
          last_l_nxt = tl;
          last_r_nxt = tr;
          if (tl == '0 && tr == '0) begin
            // stop at once
            goal_l_nxt = '0;
            goal_r_nxt = '0;
            cur_l_nxt  = '0;
            cur_r_nxt  = '0;
            armed_nxt  = 1'b0;
            ticks_nxt  = '0;
          end else begin
            goal_l_nxt = tl;
            goal_r_nxt = tr;
            inc_l_nxt  = step_l;
            inc_r_nxt  = step_r;
            armed_nxt  = 1'b1;
          end
        end
      end else begin
        res.valid = 1'b1;
        if (armed_r) begin
          // counter load tick gives no word
          ticks_nxt = CNT_W'(RAMP_TICKS);
          armed_nxt = 1'b0;
          res.valid = 1'b0;
        end else if (ticks_r != '0) begin
          ticks_nxt = ticks_r - 1'b1;
          cur_l_nxt = sat17({cur_l_r[VAL_W-1], cur_l_r} + {inc_l_r[VAL_W-1], inc_l_r});
          cur_r_nxt = sat17({cur_r_r[VAL_W-1], cur_r_r} + {inc_r_r[VAL_W-1], inc_r_r});
          if (ticks_r != CNT_W'(1)) begin
            rep_l       = cur_l_nxt;
            rep_r       = cur_r_nxt;
            rep_ramping = 1'b1;
          end
        end
      end
    end

    dl = split(rep_l);
    dr = split(rep_r);
    res.word.left_forward   = dl.fwd;
    res.word.left_backward  = dl.back;
    res.word.right_forward  = dr.fwd;
    res.word.right_backward = dr.back;
    res.word.ramping        = rep_ramping;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_l_r <= '0;
      last_r_r <= '0;
      goal_l_r <= '0;
      goal_r_r <= '0;
      cur_l_r  <= '0;
      cur_r_r  <= '0;
      inc_l_r  <= '0;
      inc_r_r  <= '0;
      ticks_r  <= '0;
      armed_r  <= 1'b0;
    end else begin
      last_l_r <= last_l_nxt;
      last_r_r <= last_r_nxt;
      goal_l_r <= goal_l_nxt;
      goal_r_r <= goal_r_nxt;
      cur_l_r  <= cur_l_nxt;
      cur_r_r  <= cur_r_nxt;
      inc_l_r  <= inc_l_nxt;
      inc_r_r  <= inc_r_nxt;
      ticks_r  <= ticks_nxt;
      armed_r  <= armed_nxt;
    end
  end

endmodule

// ----- bench/dual_motor_velocity_ramp_core_tb.sv -----
// self-checking bench for dual_motor_velocity_ramp_core: directed and random command/tick words,
// duty words predicted in the bench and checked in order; random idling on both channels
// depends on dmvr_pkg and the rtl of the block
`timescale 1ns / 100ps

module dual_motor_velocity_ramp_core_tb import dmvr_pkg::*; ();

  localparam int RAMP_LEN    = int'(RAMP_TICKS_DEF);
  localparam int NUM_WORDS   = 1600;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 20;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  in_word_t  pend_q[$];
  out_word_t exp_duty_q[$];
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  int        send_pause = 0;
  int        stall_left = 0;
  bit        send_calm = 1'b0;
  bit        recv_calm = 1'b0;

  // bench copy of the ramp state
  logic signed [VAL_W-1:0] last_l = '0, last_r = '0;
  logic signed [VAL_W-1:0] goal_l = '0, goal_r = '0;
  logic signed [VAL_W-1:0] cur_l = '0, cur_r = '0;
  logic signed [VAL_W-1:0] inc_l = '0, inc_r = '0;
  logic [CNT_W-1:0]        tick_cnt = '0;
  bit                      armed = 1'b0;

  // stimulus-side memory of the last command sent
  logic [VAL_W-1:0] sent_l = '0, sent_r = '0;
  int               gen_cnt = 0;

  dual_motor_velocity_ramp_core #(
    .RAMP_TICKS(RAMP_TICKS_DEF)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #5 clk = ~clk;

  function automatic int clamp_duty(input int v);
    if (v > 32767) return 32767;
    if (v < -32767) return -32767;
    return v;
  endfunction

  function automatic void split_duty(input int v, output logic [DUTY_W-1:0] fwd,
                                     output logic [DUTY_W-1:0] back);
    int c;
    c = clamp_duty(v);
    if (c >= 0) begin
      fwd  = c[DUTY_W-1:0];
      back = '0;
    end else begin
      fwd  = '0;
      back = DUTY_W'(-c);
    end
  endfunction

  function automatic void duty_word(input int l, input int r, input bit busy);
    out_word_t w;
    split_duty(l, w.left_forward, w.left_backward);
    split_duty(r, w.right_forward, w.right_backward);
    w.ramping = busy;
    exp_duty_q.push_back(w);
  endfunction

  // advance the ramp state by one accepted word and queue any duty word it gives
  function automatic void ramp_predict(input in_word_t w);
    int tl, tr;
    if (w.opcode == OP_CMD) begin
      tl = clamp_duty(int'(w.target_left));
      tr = clamp_duty(int'(w.target_right));
      if (tl == int'(last_l) && tr == int'(last_r)) return;
      last_l = VAL_W'(tl);
      last_r = VAL_W'(tr);
      if (tl == 0 && tr == 0) begin
        goal_l   = '0;
        goal_r   = '0;
        cur_l    = '0;
        cur_r    = '0;
        armed    = 1'b0;
        tick_cnt = '0;
      end else begin
        goal_l = VAL_W'(tl);
        goal_r = VAL_W'(tr);
        inc_l  = VAL_W'(clamp_duty((tl - int'(cur_l)) / RAMP_LEN));
        inc_r  = VAL_W'(clamp_duty((tr - int'(cur_r)) / RAMP_LEN));
        armed  = 1'b1;
      end
      return;
    end
    if (armed) begin
      tick_cnt = RAMP_LEN[CNT_W-1:0];
      armed    = 1'b0;
      if (tick_cnt != 0) return;
    end else if (tick_cnt != 0) begin
      tick_cnt = tick_cnt - 1'b1;
      cur_l    = VAL_W'(clamp_duty(int'(cur_l) + int'(inc_l)));
      cur_r    = VAL_W'(clamp_duty(int'(cur_r) + int'(inc_r)));
      if (tick_cnt != 0) begin
        duty_word(int'(cur_l), int'(cur_r), 1'b1);
        return;
      end
    end
    duty_word(int'(goal_l), int'(goal_r), 1'b0);
  endfunction

  function automatic int pick_pause(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VAL_W-1:0] pick_target();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h8001;
      3: return '0;
      4: return 16'($urandom_range(0, 400)) - 16'd200;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_cmd(input logic [VAL_W-1:0] l, input logic [VAL_W-1:0] r);
    in_word_t w;
    w.opcode       = OP_CMD;
    w.target_left  = l;
    w.target_right = r;
    pend_q.push_back(w);
    if (l != sent_l || r != sent_r) gen_cnt++;
    sent_l = l;
    sent_r = r;
  endtask

  task automatic push_ticks(input int n);
    in_word_t w;
    repeat (n) begin
      w.opcode       = OP_TICK;
      w.target_left  = 16'($urandom);
      w.target_right = 16'($urandom);
      pend_q.push_back(w);
      gen_cnt++;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_cnt++;
      if (err_cnt <= 40)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_duty(input out_word_t got);
    out_word_t want;
    if (exp_duty_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 40)
        $display("%0t: unexpected word, expected none, got %h", $time, got);
      return;
    end
    want = exp_duty_q.pop_front();
    check_field("left_forward", want.left_forward, got.left_forward);
    check_field("left_backward", want.left_backward, got.left_backward);
    check_field("right_forward", want.right_forward, got.right_forward);
    check_field("right_backward", want.right_backward, got.right_backward);
    check_field("ramping", want.ramping, got.ramping);
  endtask

  // driver: predicts at acceptance, then offers the next word or idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) ramp_predict(in_word);
      if (!in_valid || !in_stall) begin
        if ($urandom_range(0, 63) == 0) send_calm = ~send_calm;
        if (send_pause > 0) begin
          send_pause--;
          in_valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          in_word    <= pend_q.pop_front();
          in_valid   <= 1'b1;
          send_pause = pick_pause(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks accepted words and stalls the result channel at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_duty(out_word);
      if ($urandom_range(0, 63) == 0) recv_calm = ~recv_calm;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall  <= 1'b0;
        stall_left = pick_pause(recv_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    // idle tick, extremes, duplicate after saturation, command mid-ramp, stop
    push_ticks(1);
    push_cmd(16'h7fff, 16'h8000);
    push_cmd(16'h7fff, 16'h8001);
    push_ticks(4);
    push_cmd(16'h8001, 16'h7fff);
    push_ticks(3);
    push_cmd('0, '0);
    push_ticks(1);
    push_cmd('0, '0);
    push_cmd(16'h0001, 16'hffff);
    push_ticks(3);
    push_cmd(16'h00c8, '0);
    push_ticks(3);
    push_cmd('0, 16'h8000);
    push_ticks(2);

    while (gen_cnt < NUM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        push_cmd(pick_target(), pick_target());
        if ($urandom_range(0, 99) < 8)
          push_ticks($urandom_range(RAMP_LEN - 5, RAMP_LEN + 15));
        else
          push_ticks($urandom_range(1, 25));
      end else if (r < 70) begin
        push_cmd(sent_l, sent_r);
      end else if (r < 78) begin
        push_cmd('0, '0);
      end else if (r < 90) begin
        push_ticks($urandom_range(1, 4));
      end else if ($urandom_range(0, 1) == 0) begin
        push_cmd(16'($urandom), 16'($urandom));
      end else begin
        push_ticks(1);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_valid) @(posedge clk);
    while (exp_duty_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (exp_duty_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d words still expected", $time, exp_duty_q.size());
    end

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
